// ===== design/ssm_pkg.sv =====
// ssm_pkg: shared types, constants and glyph functions for the
// seven-segment scan marquee driver; used by the driver and by ssm_decimal.
// depends on nothing
package ssm_pkg;

  localparam int MARQUEE_CAPACITY_DEF = 64;
  localparam int DIGIT_COUNT          = 3;

  localparam logic [9:0] PERIOD_RST    = 10'd500;
  localparam logic [3:0] START_WAIT_RST = 4'd4;
  localparam logic [3:0] END_WAIT_RST   = 4'd1;

  // configuration register indexes
  localparam logic [1:0] CFG_PERIOD     = 2'd0;
  localparam logic [1:0] CFG_START_WAIT = 2'd1;
  localparam logic [1:0] CFG_END_WAIT   = 2'd2;

  typedef enum logic [1:0] {
    CMD_NUMBER = 2'd0,
    CMD_TEXT   = 2'd1,
    CMD_CHAR   = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  // how the digit patterns change when a request leaves the input stage
  typedef enum logic [1:0] {
    UPD_NONE   = 2'd0,
    UPD_NUMBER = 2'd1,
    UPD_TEXT   = 2'd2,
    UPD_BUFFER = 2'd3
  } upd_e;

  typedef struct packed {
    logic [1:0]        command;
    logic signed [15:0] number_value;
    logic [7:0]        char_left;
    logic [7:0]        char_middle;
    logic [7:0]        char_right;
    logic [1:0]        text_length;
    logic              marquee_last;
  } in_t;

  typedef struct packed {
    logic [7:0] segment_drive;
    logic [2:0] digit_enable;
  } out_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = 8'h7E;
      4'd1:    g = 8'h30;
      4'd2:    g = 8'h6D;
      4'd3:    g = 8'h79;
      4'd4:    g = 8'h33;
      4'd5:    g = 8'h5B;
      4'd6:    g = 8'h1F;
      4'd7:    g = 8'h70;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h73;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] letter_glyph(input logic [4:0] l);
    logic [7:0] g;
    unique case (l)
      5'd0:    g = 8'h77;
      5'd1:    g = 8'h1F;
      5'd2:    g = 8'h0D;
      5'd3:    g = 8'h3D;
      5'd4:    g = 8'h4F;
      5'd5:    g = 8'h47;
      5'd6:    g = 8'h5E;
      5'd7:    g = 8'h37;
      5'd8:    g = 8'h10;
      5'd9:    g = 8'h3C;
      5'd10:   g = 8'h57;
      5'd11:   g = 8'h0E;
      5'd12:   g = 8'h54;
      5'd13:   g = 8'h15;
      5'd14:   g = 8'h1D;
      5'd15:   g = 8'h67;
      5'd16:   g = 8'h73;
      5'd17:   g = 8'h05;
      5'd18:   g = 8'h5B;
      5'd19:   g = 8'h0F;
      5'd20:   g = 8'h1C;
      5'd21:   g = 8'h2A;
      5'd22:   g = 8'h2B;
      5'd23:   g = 8'h37;
      5'd24:   g = 8'h3B;
      5'd25:   g = 8'h6D;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // letters of either case and the dash; everything else is blank
  function automatic logic [7:0] font_glyph(input logic [7:0] c);
    logic [7:0] g;
    g = 8'h00;
    if (c == 8'd45) begin
      g = 8'h01;
    end else if (c >= 8'd65 && c <= 8'd90) begin
      g = letter_glyph(5'(c - 8'd65));
    end else if (c >= 8'd97 && c <= 8'd122) begin
      g = letter_glyph(5'(c - 8'd97));
    end
    return g;
  endfunction

endpackage

// ===== design/ssm_ram.sv =====
// ssm_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module ssm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ssm_decimal.sv =====
// ssm_decimal: signed 16-bit value to three decimal digit patterns
// with leading blanks and the point as minus sign; uses ssm_pkg
module ssm_decimal
  import ssm_pkg::*;
(
  input  logic signed [15:0] value_i,
  output logic [2:0][7:0]    pattern_o
);

  // reciprocals for divide by 10, 100 and 1000, exact for values up to 32768
  localparam logic [31:0] RECIP_10   = 32'd52429;
  localparam logic [33:0] RECIP_100  = 34'd167773;
  localparam logic [33:0] RECIP_1000 = 34'd134218;

  logic        neg;
  logic [15:0] mag;
  logic [31:0] prod1;
  logic [33:0] prod2;
  logic [33:0] prod3;
  logic [11:0] q1;
  logic [8:0]  q2;
  logic [5:0]  q3;
  logic [15:0] r0;
  logic [11:0] r1;
  logic [8:0]  r2;

  always_comb begin
    neg   = value_i[15];
    mag   = neg ? (~value_i + 16'd1) : value_i;
    prod1 = {16'b0, mag} * RECIP_10;
    prod2 = {18'b0, mag} * RECIP_100;
    prod3 = {18'b0, mag} * RECIP_1000;
    q1    = prod1[30:19];
    q2    = prod2[32:24];
    q3    = prod3[32:27];
    r0    = mag - ({4'b0, q1} * 16'd10);
    r1    = q1 - ({3'b0, q2} * 12'd10);
    r2    = q2 - ({3'b0, q3} * 9'd10);

    pattern_o[2] = digit_glyph(r0[3:0]) | {neg, 7'b0};
    pattern_o[1] = (mag < 16'd10) ? 8'h00 : digit_glyph(r1[3:0]);
    pattern_o[0] = (mag < 16'd100) ? 8'h00 : digit_glyph(r2[3:0]);
  end

endmodule

// ===== design/seven_segment_scan_marquee_driver.sv =====
// seven_segment_scan_marquee_driver: three-digit multiplexed display driver
//
// Requests arrive on in_valid_i/in_ready_o carrying an in_t: show number,
// show text, load one marquee character, or tick. Only a tick makes a result,
// an out_t on out_valid_o/out_ready_i: active-low segments of one digit and
// its one-hot enable. A request is taken every cycle unless a stalled tick
// holds the second stage; a tick's result passes the input stage, then the
// result register, and is then valid on out_valid_o.
// The input stage updates counters, marquee position and the
// character buffer and issues buffer reads; the second stage updates the
// three digit patterns and loads the result register.
// The character buffer is held three times in ssm_ram so that the three
// shown characters are read together.
// When the receiver stalls, a tick waits in the second stage and in_ready_o
// drops only while that tick cannot move; other requests keep flowing.
// Reset empties both stages, blanks the display, stops the marquee and puts
// the registers back to period 500, start wait 4 and end wait 1. The buffer
// itself is not cleared. Configuration writes on cfg_we_i take effect at once.
module seven_segment_scan_marquee_driver
  import ssm_pkg::*;
#(
  parameter int MARQUEE_CAPACITY = MARQUEE_CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [9:0] cfg_data_i
);

  localparam int AW = $clog2(MARQUEE_CAPACITY);
  localparam int CW = $clog2(MARQUEE_CAPACITY + 1);
  localparam int PW = $clog2(MARQUEE_CAPACITY + 16) + 1;
  localparam int EW = PW + 1;

  localparam logic [CW-1:0]        CAP_C = CW'(MARQUEE_CAPACITY);
  localparam logic signed [EW-1:0] THREE = EW'(3);
  localparam logic signed [EW-1:0] ZERO  = EW'(0);

  typedef struct packed {
    upd_e             upd;
    logic             tick;
    logic [1:0]       digit;
    logic [15:0]      number_value;
    logic [2:0][7:0]  chars;
    logic [1:0]       text_length;
    logic [2:0]       buf_valid;
    logic [2:0]       buf_fwd;
  } stage_t;

  // configuration
  logic [9:0] period_q;
  logic [3:0] start_wait_q;
  logic [3:0] end_wait_q;

  // input stage state
  logic [9:0]           scan_q, scan_d;
  logic [1:0]           digit_q, digit_d;
  logic [CW-1:0]        mq_count_q, mq_count_d;
  logic signed [PW-1:0] pos_q, pos_d;
  logic [CW-1:0]        load_q, load_d;

  logic                 p_valid_q;
  stage_t               p_q, p_d;
  logic                 p_consume;
  logic                 accept;

  logic [2:0][7:0]      pattern_q, pattern_d;
  logic                 out_valid_q;
  out_t                 out_q;

  logic                 wr_en;
  logic [CW-1:0]        load_inc;
  logic signed [EW-1:0] pos_x, cnt_x, base, vcnt, pos_inc, lim_wrap;
  logic signed [EW-1:0] idx [3];
  logic [2:0][AW-1:0]   raddr;
  logic [2:0][7:0]      rdata;
  logic                 step;
  logic [1:0]           dig_use;
  logic [9:0]           scan_use;

  logic [2:0][7:0]      num_pattern;
  logic [7:0]           seg_pat;
  logic [2:0]           seg_en;

  assign accept     = in_valid_i && in_ready_o;
  assign p_consume  = p_valid_q && (!p_q.tick || !out_valid_q || out_ready_i);
  assign in_ready_o = !p_valid_q || p_consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= PERIOD_RST;
      start_wait_q <= START_WAIT_RST;
      end_wait_q   <= END_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PERIOD:     period_q     <= cfg_data_i;
        CFG_START_WAIT: start_wait_q <= cfg_data_i[3:0];
        CFG_END_WAIT:   end_wait_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_comb begin
    scan_d     = scan_q;
    digit_d    = digit_q;
    mq_count_d = mq_count_q;
    pos_d      = pos_q;
    load_d     = load_q;
    wr_en      = 1'b0;
    step       = 1'b0;
    scan_use   = scan_q;
    dig_use    = digit_q;
    load_inc   = (load_q < CAP_C) ? load_q + CW'(1) : load_q;

    pos_x    = EW'(pos_q);
    cnt_x    = $signed({{(EW - CW){1'b0}}, mq_count_q});
    pos_inc  = pos_x + EW'(1);
    lim_wrap = cnt_x - THREE + $signed({{(EW - 4){1'b0}}, end_wait_q});
    base     = pos_x;
    vcnt     = cnt_x;

    p_d              = '0;
    p_d.upd          = UPD_NONE;
    p_d.digit        = digit_q;
    p_d.number_value = in_data_i.number_value;
    p_d.chars[0]     = in_data_i.char_left;
    p_d.chars[1]     = in_data_i.char_middle;
    p_d.chars[2]     = in_data_i.char_right;
    p_d.text_length  = in_data_i.text_length;

    if (accept) begin
      unique case (cmd_e'(in_data_i.command))
        CMD_NUMBER: begin
          mq_count_d = '0;
          p_d.upd    = UPD_NUMBER;
        end
        CMD_TEXT: begin
          mq_count_d = '0;
          p_d.upd    = UPD_TEXT;
        end
        CMD_CHAR: begin
          mq_count_d = '0;
          wr_en      = (load_q < CAP_C);
          load_d     = load_inc;
          if (in_data_i.marquee_last) begin
            mq_count_d = load_inc;
            pos_d      = '0;
            load_d     = '0;
            p_d.upd    = UPD_BUFFER;
            base       = ZERO;
            vcnt       = $signed({{(EW - CW){1'b0}}, load_inc});
            // character written this cycle may be one of the three shown
            for (int k = 0; k < DIGIT_COUNT; k++) begin
              p_d.buf_fwd[k] = wr_en && (load_q == CW'(k));
            end
          end
        end
        CMD_TICK: begin
          step = (scan_q == 10'd0) || (period_q != 10'd0 && scan_q >= period_q);
          if (step) begin
            scan_use = '0;
            dig_use  = '0;
            if (mq_count_q != '0) begin
              if (pos_x >= ZERO && pos_x <= cnt_x - THREE) begin
                p_d.upd = UPD_BUFFER;
              end
              if (pos_inc >= lim_wrap) begin
                pos_d = PW'(-$signed({{(EW - 4){1'b0}}, start_wait_q}));
              end else begin
                pos_d = pos_inc[PW-1:0];
              end
            end
          end
          p_d.tick  = 1'b1;
          p_d.digit = dig_use;
          scan_d    = scan_use + 10'd1;
          digit_d   = (dig_use == 2'd2) ? 2'd0 : dig_use + 2'd1;
        end
        default: ;
      endcase
    end

    for (int k = 0; k < DIGIT_COUNT; k++) begin
      idx[k]           = base + EW'(k);
      raddr[k]         = idx[k][AW-1:0];
      p_d.buf_valid[k] = (idx[k] >= ZERO) && (idx[k] < vcnt);
    end
  end

  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_buf
    ssm_ram #(
      .WIDTH(8),
      .DEPTH(MARQUEE_CAPACITY)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en),
      .waddr_i(load_q[AW-1:0]),
      .wdata_i(in_data_i.char_left),
      .re_i   (accept),
      .raddr_i(raddr[g]),
      .rdata_o(rdata[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      digit_q    <= '0;
      mq_count_q <= '0;
      pos_q      <= '0;
      load_q     <= '0;
      p_valid_q  <= 1'b0;
    end else begin
      scan_q     <= scan_d;
      digit_q    <= digit_d;
      mq_count_q <= mq_count_d;
      pos_q      <= pos_d;
      load_q     <= load_d;
      if (accept) begin
        p_valid_q <= 1'b1;
      end else if (p_consume) begin
        p_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q <= p_d;
    end
  end

  // second stage: digit patterns and result
  ssm_decimal u_decimal (
    .value_i  (p_q.number_value),
    .pattern_o(num_pattern)
  );

  always_comb begin
    pattern_d = pattern_q;
    unique case (p_q.upd)
      UPD_NUMBER: pattern_d = num_pattern;
      UPD_TEXT: begin
        for (int k = 0; k < DIGIT_COUNT; k++) begin
          pattern_d[k] = (2'(k) < p_q.text_length) ? font_glyph(p_q.chars[k]) : 8'h00;
        end
      end
      UPD_BUFFER: begin
        for (int k = 0; k < DIGIT_COUNT; k++) begin
          pattern_d[k] = !p_q.buf_valid[k] ? 8'h00 :
                         font_glyph(p_q.buf_fwd[k] ? p_q.chars[0] : rdata[k]);
        end
      end
      default: ;
    endcase

    unique case (p_q.digit)
      2'd1: begin
        seg_pat = pattern_d[1];
        seg_en  = 3'b010;
      end
      2'd2: begin
        seg_pat = pattern_d[2];
        seg_en  = 3'b100;
      end
      default: begin
        seg_pat = pattern_d[0];
        seg_en  = 3'b001;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (p_consume) begin
        pattern_q <= pattern_d;
      end
      if (p_consume && p_q.tick) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_consume && p_q.tick) begin
      out_q.segment_drive <= ~seg_pat;
      out_q.digit_enable  <= seg_en;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_enable_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(out_data_o.digit_enable))
    else $error("digit enable not one-hot");

  a_tick_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && p_q.tick && out_valid_q && !out_ready_i) |=>
      (p_valid_q && p_q.tick && $stable(p_q.digit)))
    else $error("stalled tick left the second stage");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q != 2'd3)
    else $error("scan digit out of range");

  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_q <= CAP_C)
    else $error("load count beyond buffer");

  a_pos_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(pos_q) >= -EW'(15))
    else $error("marquee position below start wait floor");
`endif

endmodule
